/* hw/rtl/sha256_digest_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// sha256 digest engine assertion macros
// property shorthands used by the top level checks
// ----------------------------------------------------------------------------
`ifndef SHA256_DIGEST_ENGINE_TOP_ASSERT_SVH
`define SHA256_DIGEST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define SHA_DE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha_de check failed");

// next-cycle implication
`define SHA_DE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha_de check failed");

`endif

/* hw/rtl/sha_de_pkg.sv */
// ----------------------------------------------------------------------------
// sha_de_pkg
// shared types, constants and round constants of the sha256 engine
// ----------------------------------------------------------------------------
package sha_de_pkg;

  localparam int unsigned QDepth = 4;

  typedef struct packed {
    logic        msg_end;
    logic [31:0] word;
  } q_entry_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [7:0] sh;
    sh = 8'(7 - idx) * 8'd32;
    return 32'(InitHash >> sh);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha_de_front.sv */
// ----------------------------------------------------------------------------
// sha_de_front
// byte intake, word packing, length count and message padding
// ----------------------------------------------------------------------------
module sha_de_front import sha_de_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output q_entry_t    q_entry_o
);

  localparam logic FsIn  = 1'b0;
  localparam logic FsPad = 1'b1;
  localparam logic [1:0] PhMark = 2'd0;
  localparam logic [1:0] PhZero = 2'd1;
  localparam logic [1:0] PhLen  = 2'd2;

  logic        state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  lidx_q, lidx_d;
  logic [63:0] len_q, len_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [5:0]  fill_q, fill_d;
  logic [23:0] acc_q, acc_d;
  logic        byte_go;
  logic [7:0]  byte_val;
  logic        final_w;
  logic        room;
  logic        take;

  assign room = !q_full_i;
  assign in_ready_o = (state_q == FsIn) && room;
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    byte_go  = 1'b0;
    byte_val = 8'h00;
    final_w  = 1'b0;
    state_d  = state_q;
    phase_d  = phase_q;
    lidx_d   = lidx_q;
    len_d    = len_q;
    bitlen_d = bitlen_q;
    unique case (state_q)
      FsIn: begin
        if (take) begin
          if (has_byte_i) begin
            byte_go  = 1'b1;
            byte_val = data_byte_i;
            bitlen_d = bitlen_q + 64'd8;
          end
          if (end_of_message_i) begin
            len_d    = bitlen_d;
            bitlen_d = '0;
            state_d  = FsPad;
            phase_d  = PhMark;
          end
        end
      end
      FsPad: begin
        if (room) begin
          byte_go = 1'b1;
          unique case (phase_q)
            PhMark: begin
              byte_val = 8'h80;
              phase_d  = PhZero;
            end
            PhZero: begin
              if (fill_q == 6'd56) begin
                byte_val = len_q[63:56];
                len_d    = {len_q[55:0], 8'h00};
                lidx_d   = 3'd1;
                phase_d  = PhLen;
              end
            end
            PhLen: begin
              byte_val = len_q[63:56];
              len_d    = {len_q[55:0], 8'h00};
              lidx_d   = lidx_q + 3'd1;
              if (lidx_q == 3'd7) begin
                final_w = 1'b1;
                state_d = FsIn;
              end
            end
            default: phase_d = PhMark;
          endcase
        end
      end
      default: state_d = FsIn;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    acc_d  = acc_q;
    if (byte_go) begin
      fill_d = fill_q + 6'd1;
      acc_d  = {acc_q[15:0], byte_val};
    end
  end

  assign q_push_o          = byte_go && (fill_q[1:0] == 2'd3);
  assign q_entry_o.word    = {acc_q, byte_val};
  assign q_entry_o.msg_end = final_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FsIn;
      phase_q  <= PhMark;
      lidx_q   <= '0;
      bitlen_q <= '0;
      fill_q   <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      lidx_q   <= lidx_d;
      bitlen_q <= bitlen_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    acc_q <= acc_d;
  end

endmodule

/* hw/rtl/sha_de_fifo.sv */
// ----------------------------------------------------------------------------
// sha_de_fifo
// short word queue between the front and the compression core
// ----------------------------------------------------------------------------
module sha_de_fifo import sha_de_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  q_entry_t mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* hw/rtl/sha_de_core.sv */
// ----------------------------------------------------------------------------
// sha_de_core
// block load, message schedule, 64 rounds and digest output
// ----------------------------------------------------------------------------
module sha_de_core import sha_de_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  q_entry_t    q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [1:0] CsLoad = 2'd0;
  localparam logic [1:0] CsRnd  = 2'd1;
  localparam logic [1:0] CsAdd  = 2'd2;
  localparam logic [1:0] CsOut  = 2'd3;

  logic [1:0]  state_q;
  logic [5:0]  cnt_q;
  logic        fin_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];

  logic [31:0] s0, s1, wnew, wt, t1, t2, bs0, bs1, ch, maj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    wt   = (cnt_q[5:4] == 2'd0) ? w_q[0] : wnew;
    bs1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + bs1 + ch + round_k(cnt_q) + wt;
    bs0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = bs0 + maj;
  end

  assign q_pop_o       = (state_q == CsLoad) && !q_empty_i;
  assign out_valid_o   = (state_q == CsOut);
  assign digest_word_o = h_q[cnt_q[2:0]];
  assign word_index_o  = cnt_q[2:0];
  assign last_word_o   = (cnt_q[2:0] == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CsLoad;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
    end else begin
      unique case (state_q)
        CsLoad: begin
          if (q_pop_o) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd15) begin
              fin_q   <= q_data_i.msg_end;
              cnt_q   <= '0;
              state_q <= CsRnd;
            end
          end
        end
        CsRnd: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= CsAdd;
        end
        CsAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          cnt_q   <= '0;
          state_q <= fin_q ? CsOut : CsLoad;
        end
        CsOut: begin
          if (out_ready_i) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q[2:0] == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
              cnt_q   <= '0;
              state_q <= CsLoad;
            end
          end
        end
        default: state_q <= CsLoad;
      endcase
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= q_data_i.word;
      if (cnt_q == 6'd15) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (state_q == CsRnd) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

/* hw/rtl/sha256_digest_engine_top.sv */
// ----------------------------------------------------------------------------
// sha256_digest_engine_top
// streaming sha-256 engine: message bytes in, eight digest words out
// ----------------------------------------------------------------------------
// Bytes enter one per transaction on the slave side; a transaction with tlast
// ends the message (with or without a byte, so an empty message works). The
// front packs bytes into big-endian words at one byte per cycle while the
// queue has room and, on the end transaction, appends the 0x80 marker, zero
// fill and 64-bit bit length, one padding byte per cycle while the queue has
// room (9 to 72 padding bytes). Words go through a 4-entry queue to the core,
// which loads 16 words, runs 64 rounds at one round per cycle, then folds the
// working variables into the chaining hash. After the last block the core
// presents the digest as eight transactions, word 0 (most significant) first,
// tlast on word 7, then returns to the initial hash. The front keeps taking
// bytes while the core compresses until the queue fills.
// ----------------------------------------------------------------------------
module sha256_digest_engine_top import sha_de_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_axis_tlast    // last_word
);

  `include "sha256_digest_engine_top_assert.svh"

  // queue handshake between front and core
  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_in, q_out;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha_de_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .data_byte_i      (s_axis_tdata),
    .has_byte_i       (s_axis_tuser),
    .end_of_message_i (s_axis_tlast),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (q_in)
  );

  sha_de_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  sha_de_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (m_axis_tlast)
  );

  // digest word in the low bits, index above, zero fill to 40 bits
  assign m_axis_tdata = {5'b0, word_index, digest_word};

  // the front never pushes into a full queue
  `SHA_DE_ASSERT_IMP(a_no_push_full, q_push, !q_full)
  // tlast comes with the final word index only
  `SHA_DE_ASSERT_IMP(a_last_idx, m_axis_tvalid && m_axis_tlast, word_index == 3'd7)
  // after the final word is taken the output side goes quiet
  `SHA_DE_ASSERT_NXT(a_idle_after, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                     !m_axis_tvalid)

endmodule

/* tb/tb_sha256_digest_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_sha256_digest_engine_top
// self-checking stream test of the sha-256 digest engine
// ----------------------------------------------------------------------------
// Message bytes are queued by a stimulus process and driven by a clocked
// driver with random gaps; a clocked monitor takes digest words with random
// stalls and compares each one with the digest computed by the predictor
// in this file, which hashes every accepted transaction as the engine should.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_digest_engine_top;
  import sha_de_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       msg_end;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] has_byte
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, zero above
  logic        m_axis_tlast;   // last_word

  byte_item_t   pending_bytes[$];
  digest_item_t expected_words[$];

  // predictor state
  logic [31:0] hash_state[8];
  logic [7:0]  msg_block[64];
  int unsigned block_bytes;
  logic [63:0] msg_bits;

  int unsigned mismatch_cnt;
  int unsigned words_seen;
  int unsigned messages_sent;
  int unsigned cycle_cnt;
  int unsigned hold_cycles;
  bit          in_acc;

  sha256_digest_engine_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one full block folded into the running hash
  task automatic compress_msg_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(6'(t)) + w[t];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic append_msg_byte(input logic [7:0] b);
    msg_block[block_bytes] = b;
    block_bytes = (block_bytes + 1) % 64;
    if (block_bytes == 0) compress_msg_block();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = init_word(3'(i));
    block_bytes = 0;
    msg_bits = '0;
  endtask

  // predictor: called on every accepted input transaction
  task automatic hash_byte_item(input byte_item_t it);
    logic [63:0]  len;
    digest_item_t d;
    if (it.has_byte) begin
      append_msg_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.msg_end) begin
      len = msg_bits;
      append_msg_byte(8'h80);
      while (block_bytes != 56) append_msg_byte(8'h00);
      for (int i = 0; i < 8; i++) append_msg_byte(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        expected_words.push_back(d);
      end
      restart_hash();
    end
  endtask

  // most gaps short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_msg(input int unsigned n, input bit noise);
    byte_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      // an idle item (no byte, no end) slipped in now and then
      if (noise && $urandom_range(0, 15) == 0) begin
        it.data_byte = 8'($urandom);
        it.has_byte  = 1'b0;
        it.msg_end   = 1'b0;
        pending_bytes.push_back(it);
      end
      it.data_byte = 8'($urandom);
      it.has_byte  = 1'b1;
      it.msg_end   = 1'b0;
      pending_bytes.push_back(it);
    end
    // end either rides with the last byte or comes alone
    it.data_byte = 8'($urandom);
    it.has_byte  = (n > 0) && $urandom_range(0, 1);
    it.msg_end   = 1'b1;
    if (it.has_byte) void'(pending_bytes.pop_back());
    pending_bytes.push_back(it);
    messages_sent++;
  endtask

  task automatic queue_bytes(input logic [7:0] b0, input logic [7:0] b1);
    byte_item_t it;
    it = '{data_byte: b0, has_byte: 1'b1, msg_end: 1'b0};
    pending_bytes.push_back(it);
    it = '{data_byte: b1, has_byte: 1'b1, msg_end: 1'b1};
    pending_bytes.push_back(it);
    messages_sent++;
  endtask

  task automatic drain_wait();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  // driver: offers queued items at the falling edge
  int unsigned drv_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_acc) begin
      // hold item until a rising edge takes it
    end else if (drv_gap != 0) begin
      drv_gap       <= drv_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pending_bytes[0].data_byte;
      s_axis_tuser  <= pending_bytes[0].has_byte;
      s_axis_tlast  <= pending_bytes[0].msg_end;
      void'(pending_bytes.pop_front());
      drv_gap       <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    in_acc <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      hash_byte_item('{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
                       msg_end: s_axis_tlast});
    end
  end

  // receiver ready: random stalls, or a long forced hold-off
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // monitor: compare each digest word with the oldest expectation
  always @(posedge clk_i) begin
    digest_item_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected digest word %h", m_axis_tdata);
      end else begin
        exp_w = expected_words.pop_front();
        if (m_axis_tdata[31:0] !== exp_w.digest_word ||
            m_axis_tdata[34:32] !== exp_w.word_index ||
            m_axis_tdata[39:35] !== 5'd0 ||
            m_axis_tlast !== exp_w.last_word) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: word %0d exp %h idx %0d last %0b, got %h idx %0d last %0b",
                     words_seen, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_cnt, expected_words.size());
      $display("FAIL sha256_digest_engine_top");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    drv_gap       = 0;
    hold_cycles   = 0;
    mismatch_cnt  = 0;
    words_seen    = 0;
    messages_sent = 0;
    cycle_cnt     = 0;
    restart_hash();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty message, byte extremes, byte with end, end alone, idle item
    queue_msg(0, 1'b0);
    queue_bytes(8'h00, 8'hff);
    queue_bytes(8'hff, 8'h00);
    pending_bytes.push_back('{data_byte: 8'h5a, has_byte: 1'b0, msg_end: 1'b0});
    pending_bytes.push_back('{data_byte: 8'hff, has_byte: 1'b0, msg_end: 1'b1});
    messages_sent++;
    drain_wait();

    // sender pauses until every digest is back; then a long receiver hold-off
    // while messages at the padding boundaries (55, 56, 64 bytes) are pushed in
    queue_msg(55, 1'b0);
    queue_msg(56, 1'b0);
    queue_msg(64, 1'b0);
    hold_cycles = 600;
    drain_wait();

    // random messages, mostly short with an occasional long one
    total = 0;
    while (total < 130) begin
      automatic int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      queue_msg(n, 1'b1);
      total += n + 1;
      if ($urandom_range(0, 7) == 0) drain_wait();
    end
    drain_wait();
    repeat (200) @(posedge clk_i);

    $display("covered %0d messages, %0d digest words checked, %0d mismatches",
             messages_sent, words_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("PASS sha256_digest_engine_top");
    end else begin
      $display("FAIL sha256_digest_engine_top");
    end
    $finish;
  end

endmodule
